// ===== hw/rtl/dsc_pkg.sv =====
// Shared types and constants for the dictionary segmentation checker.
`timescale 1ns / 1ps

package dsc_pkg;

	localparam int MAX_WORDS    = 512;
	localparam int MAX_WORD_LEN = 8;
	localparam int SYM_W        = 3;
	localparam int ADDR_W       = $clog2(MAX_WORDS);
	localparam int CNT_W        = 10;
	localparam int LEN_W        = 4;
	localparam int HIST_W       = MAX_WORD_LEN * SYM_W;
	localparam int REACH_W      = MAX_WORD_LEN + 1;
	localparam int TOTAL_W      = 32;

	localparam logic [SYM_W-1:0] SYM_MAX     = 3'd4;
	localparam logic             REQ_LOAD    = 1'b0;
	localparam logic             REQ_SYMBOL  = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [8:0]        word_index;
		logic [LEN_W-1:0]  word_length;
		logic [HIST_W-1:0] word_symbols;
		logic [SYM_W-1:0]  symbol;
		logic              last;
	} req_item_t;

	typedef struct packed {
		logic               pattern_possible;
		logic [TOTAL_W-1:0] possible_total;
	} rsp_item_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [HIST_W-1:0] syms;
	} word_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} dsc_state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic walk;
		logic finish;
	} dsc_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic last;
		logic out_free;
	} dsc_status_t;

endpackage

// ===== hw/rtl/dsc_ctrl.sv =====
// Controller state machine: sequences load, table walk and pattern finish.
`timescale 1ns / 1ps

module dsc_ctrl
	import dsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_type,
	output logic        req_stall,
	input  dsc_status_t status,
	output dsc_cmd_t    cmd
);

	dsc_state_t state_q;
	dsc_state_t state_next;
	logic       accept;

	assign accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req_type == REQ_SYMBOL) begin
					state_next = ST_WALK;
				end
			end
			ST_WALK: begin
				if (status.walk_done) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!status.last || status.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = accept && req_type == REQ_LOAD;
				cmd.start = accept && req_type == REQ_SYMBOL;
			end
			ST_WALK: begin
				cmd.walk = !status.walk_done;
			end
			ST_FINISH: begin
				cmd.finish = !status.last || status.out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== hw/rtl/dsc_dp.sv =====
// Datapath: word table, history registers, match logic and result register.
`timescale 1ns / 1ps

module dsc_dp
	import dsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  req_item_t   req_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	input  dsc_cmd_t    cmd,
	output dsc_status_t status,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_item_t   rsp_data
);

	word_entry_t mem [MAX_WORDS];

	logic [CNT_W-1:0]   word_count_q;
	logic [CNT_W-1:0]   limit;
	logic [CNT_W-1:0]   k_q;
	logic               issue;
	logic               rd_v_s1;
	word_entry_t        rd_data_s1;
	logic               hit_q;
	logic               last_q;
	logic [HIST_W-1:0]  hist_q;
	logic [REACH_W-1:0] reach_q;
	logic [TOTAL_W-1:0] total_q;
	logic               out_valid_q;
	rsp_item_t          out_q;
	logic               match;
	logic [LEN_W-1:0]   lm1;
	logic [LEN_W-1:0]   off_w;
	logic [SYM_W-1:0]   off;
	logic [SYM_W-1:0]   ws;
	logic [SYM_W-1:0]   ps;
	logic               reach_bit;
	logic               out_load;

	assign limit = (word_count_q > CNT_W'(MAX_WORDS)) ? CNT_W'(MAX_WORDS) : word_count_q;
	assign issue = cmd.walk && (k_q < limit);
	assign out_load = cmd.finish && last_q;

	assign status.walk_done = !(k_q < limit) && !rd_v_s1;
	assign status.last      = last_q;
	assign status.out_free  = !out_valid_q || !rsp_stall;

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	always_comb begin
		lm1       = rd_data_s1.len - LEN_W'(1);
		reach_bit = (lm1 < LEN_W'(REACH_W)) ? reach_q[lm1] : 1'b0;
		match     = (rd_data_s1.len != '0) &&
		            (rd_data_s1.len <= LEN_W'(MAX_WORD_LEN)) && reach_bit;
		for (int i = 0; i < MAX_WORD_LEN; i++) begin
			ws    = rd_data_s1.syms[SYM_W*i +: SYM_W];
			off_w = lm1 - LEN_W'(i);
			off   = off_w[SYM_W-1:0];
			ps    = hist_q[SYM_W*off +: SYM_W];
			if (LEN_W'(i) < rd_data_s1.len) begin
				if (ws > SYM_MAX || ps > SYM_MAX || ws != ps) begin
					match = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[req_data.word_index[ADDR_W-1:0]] <= {req_data.word_length,
			                                         req_data.word_symbols};
		end
		if (issue) begin
			rd_data_s1 <= mem[k_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
			k_q          <= '0;
			rd_v_s1      <= 1'b0;
			hit_q        <= 1'b0;
			last_q       <= 1'b0;
			hist_q       <= '0;
			reach_q      <= REACH_W'(1);
			total_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				word_count_q <= cfg_data;
			end
			if (cmd.start) begin
				k_q     <= '0;
				rd_v_s1 <= 1'b0;
				hit_q   <= 1'b0;
				last_q  <= req_data.last;
				hist_q  <= {hist_q[HIST_W-SYM_W-1:0], req_data.symbol};
			end else begin
				rd_v_s1 <= issue;
				if (issue) begin
					k_q <= k_q + CNT_W'(1);
				end
				if (rd_v_s1 && match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				if (last_q) begin
					reach_q <= REACH_W'(1);
					if (hit_q && total_q != '1) begin
						total_q <= total_q + TOTAL_W'(1);
					end
				end else begin
					reach_q <= {reach_q[REACH_W-2:0], hit_q};
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.pattern_possible <= hit_q;
			out_q.possible_total   <= (hit_q && total_q != '1) ? total_q + TOTAL_W'(1)
			                                                   : total_q;
		end
	end

endmodule

// ===== hw/rtl/dictionary_segmentation_checker_unit.sv =====
// Top level of the dictionary segmentation checker.
`timescale 1ns / 1ps

// Load beats (req_type 0) write one dictionary word into the 512-entry table. A symbol beat
// (req_type 1) walks table entries 0 to min(word_count, 512) - 1 through the single read port
// of the table, one entry a cycle, and stalls the request side from when it is taken until the
// walk and the finish step are through; on
// the last symbol of a pattern one response beat carries whether the pattern splits fully
// into words and the saturating count of such patterns. The response sits in an output
// register, so further requests are taken while it waits; the last symbol of the next
// pattern holds the request side stalled until the waiting response has left.
// Write word_count only while the block is idle.
module dictionary_segmentation_checker_unit
	import dsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_item_t        req_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_item_t        rsp_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	dsc_cmd_t    cmd;
	dsc_status_t status;

	assign cfg_ready = 1'b1;

	dsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_data.req_type),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	dsc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

// ===== tb/dictionary_segmentation_checker_unit_tb.sv =====
// Self-checking testbench for the dictionary segmentation checker: directed, then random.
`timescale 1ns / 1ps

module dictionary_segmentation_checker_unit_tb;
	import dsc_pkg::*;

	localparam int IDLE_LIMIT  = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam int HOLD_AFTER  = 60;
	localparam int PHASE_ITEMS = 64;

	localparam logic [SYM_W-1:0] C_WHITE  = 3'd0;
	localparam logic [SYM_W-1:0] C_BLUE   = 3'd1;
	localparam logic [SYM_W-1:0] C_BLACK  = 3'd2;
	localparam logic [SYM_W-1:0] C_RED    = 3'd3;
	localparam logic [SYM_W-1:0] C_GREEN  = 3'd4;
	localparam logic [SYM_W-1:0] C_BAD_LO = 3'd5;
	localparam logic [SYM_W-1:0] C_BAD_HI = 3'd7;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

	typedef struct packed {
		row_kind_e        kind;
		req_item_t        item;
		logic             typed;
		rsp_item_t        verdict;
		logic [CNT_W-1:0] count;
	} plan_row_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_item_t        req_data  = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_item_t        rsp_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data  = '0;

	logic [LEN_W-1:0]   dict_len  [MAX_WORDS];
	logic [HIST_W-1:0]  dict_syms [MAX_WORDS];
	logic [HIST_W-1:0]  sym_trail   = '0;
	logic [REACH_W-1:0] reach_bits  = REACH_W'(1);
	logic [TOTAL_W-1:0] match_total = '0;
	logic [CNT_W-1:0]   word_limit  = '0;

	rsp_item_t pending_verdicts [$];
	rsp_item_t oldest_verdict;
	plan_row_t plan [$];
	int        errors        = 0;
	int        verdicts_seen = 0;
	int        idle_cycles   = 0;
	bit        quiet         = 1'b0;
	bit        rsp_held      = 1'b0;

	dictionary_segmentation_checker_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit word_fits(input logic [LEN_W-1:0] len, input logic [HIST_W-1:0] syms,
			input logic [REACH_W-1:0] reach);
		logic [SYM_W-1:0] ws;
		logic [SYM_W-1:0] ps;
		if (len == 0 || len > MAX_WORD_LEN)
			return 1'b0;
		if (!reach[len - 1])
			return 1'b0;
		for (int i = 0; i < len; i++) begin
			ws = syms[SYM_W*i +: SYM_W];
			ps = sym_trail[SYM_W*(len - 1 - i) +: SYM_W];
			if (ws > SYM_MAX || ps > SYM_MAX || ws != ps)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit advance_model(input req_item_t it, output rsp_item_t verdict);
		logic [REACH_W-1:0] prev;
		bit                 hit;
		int                 n;
		verdict = '0;
		if (it.req_type == REQ_LOAD) begin
			dict_len[it.word_index]  = it.word_length;
			dict_syms[it.word_index] = it.word_symbols;
			return 1'b0;
		end
		sym_trail = {sym_trail[HIST_W-SYM_W-1:0], it.symbol};
		prev = reach_bits;
		hit  = 1'b0;
		n    = (word_limit > MAX_WORDS) ? MAX_WORDS : int'(word_limit);
		for (int k = 0; k < n && !hit; k++)
			if (word_fits(dict_len[k], dict_syms[k], prev))
				hit = 1'b1;
		reach_bits = {prev[REACH_W-2:0], hit};
		if (!it.last)
			return 1'b0;
		if (hit && match_total != '1)
			match_total++;
		verdict.pattern_possible = hit;
		verdict.possible_total   = match_total;
		reach_bits = REACH_W'(1);
		return 1'b1;
	endfunction

	function automatic req_item_t make_word(input int slot);
		req_item_t   it;
		logic [63:0] raw;
		int          len;
		int          pick;
		raw = {$urandom, $urandom};
		it  = raw[$bits(req_item_t)-1:0];
		it.req_type   = REQ_LOAD;
		it.word_index = slot[8:0];
		pick = $urandom_range(99);
		if (pick < 88) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(MAX_WORD_LEN, 4) : $urandom_range(3, 1);
			for (int i = 0; i < len; i++)
				it.word_symbols[SYM_W*i +: SYM_W] = SYM_W'($urandom_range(SYM_MAX, C_WHITE));
			if (pick >= 80)
				it.word_symbols[SYM_W*$urandom_range(len - 1, 0) +: SYM_W] =
					SYM_W'($urandom_range(C_BAD_HI, C_BAD_LO));
			it.word_length = LEN_W'(len);
		end else if (pick < 95) begin
			it.word_length = LEN_W'($urandom_range(1) ? 0 :
				$urandom_range(15, MAX_WORD_LEN + 1));
		end
		return it;
	endfunction

	function automatic req_item_t pattern_beat(input logic [SYM_W-1:0] s, input logic ends);
		req_item_t   it;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		it  = raw[$bits(req_item_t)-1:0];
		it.req_type = REQ_SYMBOL;
		it.symbol   = s;
		it.last     = ends;
		return it;
	endfunction

	function automatic plan_row_t cfg_row(input int v);
		plan_row_t r;
		r = '0;
		r.kind  = ROW_CFG;
		r.count = CNT_W'(v);
		return r;
	endfunction

	function automatic plan_row_t load_row(input int idx, input int len,
			input logic [HIST_W-1:0] syms);
		plan_row_t r;
		r = '0;
		r.kind              = ROW_ITEM;
		r.item.req_type     = REQ_LOAD;
		r.item.word_index   = 9'(idx);
		r.item.word_length  = LEN_W'(len);
		r.item.word_symbols = syms;
		return r;
	endfunction

	function automatic plan_row_t sym_row(input logic [SYM_W-1:0] s, input logic ends);
		plan_row_t r;
		r = '0;
		r.kind          = ROW_ITEM;
		r.item.req_type = REQ_SYMBOL;
		r.item.symbol   = s;
		r.item.last     = ends;
		return r;
	endfunction

	function automatic plan_row_t sym_chk(input logic [SYM_W-1:0] s, input logic ends,
			input logic ok, input int total);
		plan_row_t r;
		r = sym_row(s, ends);
		r.typed                  = 1'b1;
		r.verdict.pattern_possible = ok;
		r.verdict.possible_total   = TOTAL_W'(total);
		return r;
	endfunction

	task automatic push_req(input req_item_t it, input bit typed = 1'b0,
			input rsp_item_t fixed = '0);
		rsp_item_t verdict;
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 24) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= it;
		do @(posedge clk); while (req_stall);
		if (advance_model(it, verdict))
			pending_verdicts.push_back(typed ? fixed : verdict);
	endtask

	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (((word_limit > MAX_WORDS) ? MAX_WORDS : int'(word_limit)) + 8)
			@(posedge clk);
	endtask

	task automatic set_word_count(input logic [CNT_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		word_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int wc, input bit calm);
		int               sent;
		int               n;
		int               slot;
		bit               ok;
		int               good [$];
		logic [SYM_W-1:0] seq [$];
		settle();
		quiet = calm;
		set_word_count(CNT_W'(wc));
		n    = (wc > MAX_WORDS) ? MAX_WORDS : wc;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			good.delete();
			seq.delete();
			for (int k = 0; k < n; k++) begin
				ok = dict_len[k] != 0 && dict_len[k] <= MAX_WORD_LEN;
				for (int i = 0; i < dict_len[k]; i++)
					if (dict_syms[k][SYM_W*i +: SYM_W] > SYM_MAX)
						ok = 1'b0;
				if (ok)
					good.push_back(k);
			end
			if (good.size() != 0 && $urandom_range(99) < 70) begin
				repeat ($urandom_range(4, 1)) begin
					slot = good[$urandom_range(good.size() - 1, 0)];
					for (int i = 0; i < dict_len[slot]; i++)
						seq.push_back(dict_syms[slot][SYM_W*i +: SYM_W]);
				end
				if ($urandom_range(99) < 15)
					seq[$urandom_range(seq.size() - 1, 0)] =
						SYM_W'($urandom_range(C_BAD_HI, C_WHITE));
			end else begin
				repeat ($urandom_range(10, 1))
					seq.push_back(SYM_W'(($urandom_range(99) < 80) ?
						$urandom_range(SYM_MAX, C_WHITE) :
						$urandom_range(C_BAD_HI, C_BAD_LO)));
			end
			foreach (seq[i]) begin
				if ($urandom_range(99) < 4) begin
					push_req(make_word($urandom_range(MAX_WORDS - 1, 0)));
					sent++;
				end
				push_req(pattern_beat(seq[i], i == seq.size() - 1));
				sent++;
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		plan = '{
			cfg_row(0),
			sym_chk(C_WHITE, 1'b1, 1'b0, 0),
			load_row(0, 1, {21'd0, C_WHITE}),
			load_row(1, 2, {18'd0, C_BLACK, C_BLUE}),
			load_row(2, MAX_WORD_LEN, {8{C_GREEN}}),
			load_row(3, 0, '0),
			load_row(4, 15, '0),
			load_row(5, 1, {21'd0, C_BAD_HI}),
			load_row(511, 3, {15'd0, C_RED, C_RED, C_RED}),
			load_row(6, MAX_WORD_LEN, '1),
			cfg_row(7),
			sym_chk(C_WHITE, 1'b1, 1'b1, 1),
			sym_row(C_BLUE, 1'b0),
			sym_chk(C_BLACK, 1'b1, 1'b1, 2),
			sym_chk(C_BAD_LO, 1'b1, 1'b0, 2),
			sym_chk(C_BAD_HI, 1'b1, 1'b0, 2),
			sym_row(C_GREEN, 1'b0), sym_row(C_GREEN, 1'b0), sym_row(C_GREEN, 1'b0),
			sym_row(C_GREEN, 1'b0), sym_row(C_GREEN, 1'b0), sym_row(C_GREEN, 1'b0),
			sym_row(C_GREEN, 1'b0),
			sym_chk(C_GREEN, 1'b1, 1'b1, 3),
			sym_chk(C_BLACK, 1'b1, 1'b0, 3),
			sym_row(C_RED, 1'b0),
			load_row(3, 1, {21'd0, C_RED}),
			sym_row(C_RED, 1'b1)
		};
		foreach (plan[r]) begin
			if (plan[r].kind == ROW_CFG) begin
				settle();
				set_word_count(plan[r].count);
			end else begin
				push_req(plan[r].item, plan[r].typed, plan[r].verdict);
			end
		end
		for (int s = 0; s < MAX_WORDS; s++)
			push_req(make_word(s));
		run_phase(1, 1'b0);
		run_phase(16, 1'b0);
		run_phase(512, 1'b0);
		run_phase(0, 1'b0);
		run_phase(64, 1'b0);
		run_phase(5, 1'b1);
		run_phase(384, 1'b0);
		run_phase(40, 1'b0);
		settle();
		if (errors == 0 && pending_verdicts.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!rsp_held && verdicts_seen >= HOLD_AFTER) begin
				rsp_held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_stall <= !quiet && $urandom_range(99) < 24;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			verdicts_seen++;
			if (pending_verdicts.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, possible %0d total %0d", $time,
					rsp_data.pattern_possible, rsp_data.possible_total);
			end else begin
				oldest_verdict = pending_verdicts.pop_front();
				if (rsp_data.pattern_possible !== oldest_verdict.pattern_possible) begin
					errors++;
					$display("%0t: pattern_possible expected %0d got %0d", $time,
						oldest_verdict.pattern_possible, rsp_data.pattern_possible);
				end
				if (rsp_data.possible_total !== oldest_verdict.possible_total) begin
					errors++;
					$display("%0t: possible_total expected %0d got %0d", $time,
						oldest_verdict.possible_total, rsp_data.possible_total);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule

// ===== dictionary_segmentation_checker_unit.f =====
hw/rtl/dsc_pkg.sv
hw/rtl/dsc_ctrl.sv
hw/rtl/dsc_dp.sv
hw/rtl/dictionary_segmentation_checker_unit.sv
tb/dictionary_segmentation_checker_unit_tb.sv
